>>> rtl/core/sll_pkg.sv
// Shared types and constants of the static linked list engine.
package sll_pkg;

    localparam int FUNC_W   = 3;
    localparam int SLOT_W   = 10;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;

    localparam int NODES_DEF      = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // Operation codes carried in the func field of a request
    localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_HEAD  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_AFTER = 3'd2;
    localparam logic [FUNC_W-1:0] FN_UNL_AFTER = 3'd3;
    localparam logic [FUNC_W-1:0] FN_UNL_FIRST = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READ_NEXT = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BAD_SLOT = 3'd2,
        ST_NO_NEXT  = 3'd3,
        ST_END      = 3'd4
    } status_t;

    // Port enables of the link and value memories
    typedef struct packed {
        logic nx_re;
        logic nx_we;
        logic vl_re;
        logic vl_we;
    } mem_ctl_t;

endpackage

>>> rtl/core/sll_req_if.sv
// Request channel of the linked list engine: operation, slot and value.
interface sll_req_if;
    logic                              valid;
    logic                              ready;
    logic        [sll_pkg::FUNC_W-1:0] func;
    logic        [sll_pkg::SLOT_W-1:0] slot;
    logic signed [sll_pkg::DATA_W-1:0] data;

    modport source (output valid, func, slot, data, input ready);
    modport sink   (input valid, func, slot, data, output ready);
endinterface

>>> rtl/core/sll_rsp_if.sv
// Result channel of the linked list engine: status, slot, value and end flag.
interface sll_rsp_if;
    logic                                valid;
    logic                                ready;
    logic        [sll_pkg::STATUS_W-1:0] status;
    logic        [sll_pkg::SLOT_W-1:0]   out_slot;
    logic signed [sll_pkg::DATA_W-1:0]   out_data;
    logic                                last;

    modport source (output valid, status, out_slot, out_data, last, input ready);
    modport sink   (input valid, status, out_slot, out_data, last, output ready);
endinterface

>>> rtl/core/static_linked_list_engine.sv
// Top level of the static linked list engine: sequencer, list registers and result stages.
//
// Array-backed singly linked list. Each request on req carries one operation (clear,
// insert at head, insert after a slot, unlink after a slot, unlink the first node,
// read the next node of the walk) and yields exactly one result on rsp.
// Node slots are handed out in order by a bump counter and never reused before a clear;
// clear only rewinds the counter, so the link and value memories are never swept.
//
// Timing: clear, insert at head, unused codes and errors found at acceptance finish in
// S_IDLE; insert after passes through S_LINK, unlink first through S_POP, read next
// through S_WALK and unlink after through S_UNL1, then S_UNL2 if a successor exists.
// The link memory sets this: it has one read port with a registered read. Insert after
// writes the new slot over the old link in the same cycle that reads it. A finished
// result enters a holding stage and then the output register, which drives rsp.valid.
// Ready on req stays low while the sequencer is busy or the holding stage is full, so a
// new request is taken only after the previous result has left the holding stage. A
// stall on rsp holds one result in each stage and keeps ready on req low until the output register is taken.
//
// Reset: the list is empty, the walk is idle and no result is pending. No clearing
// pass is needed; entries are only read after they have been written.
module static_linked_list_engine #(
    parameter int NODES      = sll_pkg::NODES_DEF,
    parameter int VALUE_BITS = sll_pkg::VALUE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    sll_req_if.sink   req,
    sll_rsp_if.source rsp
);
    import sll_pkg::*;

    localparam int PW = $clog2(NODES + 1);             // pointer incl. null marker
    localparam int SW = $clog2(NODES);                 // memory index
    localparam int CW = (PW > SLOT_W) ? PW : SLOT_W;   // slot compare width
    localparam logic [PW-1:0] NULL_PTR = PW'(NODES);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LINK = 6'b000010,
        S_UNL1 = 6'b000100,
        S_UNL2 = 6'b001000,
        S_POP  = 6'b010000,
        S_WALK = 6'b100000
    } state_t;

    // Sequencer and list state
    state_t        state_reg, state_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] alloc_reg, alloc_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic          started_reg, started_next;
    logic [SW-1:0] op_slot_reg, op_slot_next;

    // Holding stage and output register
    logic                rs_valid_reg;
    logic [STATUS_W-1:0] rs_status_reg;
    logic [SLOT_W-1:0]   rs_slot_reg;
    logic [DATA_W-1:0]   rs_data_reg;
    logic                rs_last_reg;
    logic                ov_reg;
    logic [STATUS_W-1:0] o_status_reg;
    logic [SLOT_W-1:0]   o_slot_reg;
    logic [DATA_W-1:0]   o_data_reg;
    logic                o_last_reg;

    // Completion of the current request
    logic                fin;
    logic [STATUS_W-1:0] fin_status;
    logic [SLOT_W-1:0]   fin_slot;
    logic [DATA_W-1:0]   fin_data;
    logic                fin_last;

    // Memory ports
    mem_ctl_t              mem_ctl;
    logic [SW-1:0]         nx_raddr, nx_waddr, vl_raddr, vl_waddr;
    logic [PW-1:0]         nx_wdata, nx_rdata;
    logic [VALUE_BITS-1:0] vl_wdata, vl_rdata;

    logic          accept;
    logic          full;
    logic          slot_ok;
    logic [PW-1:0] walk_ptr;
    logic          out_load;

    assign req.ready = (state_reg == S_IDLE) && !rs_valid_reg;
    assign accept    = req.valid && req.ready;
    assign full      = (alloc_reg >= NULL_PTR);
    assign slot_ok   = (CW'(req.slot) < CW'(alloc_reg));
    assign walk_ptr  = started_reg ? cur_reg : head_reg;
    assign out_load  = rs_valid_reg && (!ov_reg || rsp.ready);

    sll_store #(
        .NODES      (NODES),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk      (clk),
        .ctl      (mem_ctl),
        .nx_raddr (nx_raddr),
        .nx_waddr (nx_waddr),
        .nx_wdata (nx_wdata),
        .nx_rdata (nx_rdata),
        .vl_raddr (vl_raddr),
        .vl_waddr (vl_waddr),
        .vl_wdata (vl_wdata),
        .vl_rdata (vl_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        alloc_next   = alloc_reg;
        cur_next     = cur_reg;
        started_next = started_reg;
        op_slot_next = op_slot_reg;

        fin        = 1'b0;
        fin_status = ST_OK;
        fin_slot   = '0;
        fin_data   = '0;
        fin_last   = 1'b0;

        mem_ctl  = '0;
        nx_raddr = '0;
        nx_waddr = '0;
        nx_wdata = '0;
        vl_raddr = '0;
        vl_waddr = '0;
        vl_wdata = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.func)
                        FN_CLEAR:
                        begin
                            head_next    = NULL_PTR;
                            alloc_next   = '0;
                            cur_next     = NULL_PTR;
                            started_next = 1'b0;
                            fin          = 1'b1;
                        end
                        FN_INS_HEAD:
                        begin
                            fin = 1'b1;
                            if (full)
                            begin
                                fin_status = ST_FULL;
                            end
                            else
                            begin
                                // New node links to the old head
                                mem_ctl.nx_we = 1'b1;
                                mem_ctl.vl_we = 1'b1;
                                nx_waddr      = alloc_reg[SW-1:0];
                                nx_wdata      = head_reg;
                                vl_waddr      = alloc_reg[SW-1:0];
                                vl_wdata      = VALUE_BITS'($unsigned(req.data));
                                head_next     = alloc_reg;
                                alloc_next    = alloc_reg + PW'(1);
                                fin_slot      = SLOT_W'(alloc_reg);
                            end
                        end
                        FN_INS_AFTER:
                        begin
                            if (full)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end
                            else if (!slot_ok)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_BAD_SLOT;
                            end
                            else
                            begin
                                // Fetch the old link while pointing the slot at the new node
                                mem_ctl.nx_re = 1'b1;
                                mem_ctl.nx_we = 1'b1;
                                mem_ctl.vl_we = 1'b1;
                                nx_raddr      = SW'(req.slot);
                                nx_waddr      = SW'(req.slot);
                                nx_wdata      = alloc_reg;
                                vl_waddr      = alloc_reg[SW-1:0];
                                vl_wdata      = VALUE_BITS'($unsigned(req.data));
                                op_slot_next  = alloc_reg[SW-1:0];
                                alloc_next    = alloc_reg + PW'(1);
                                state_next    = S_LINK;
                            end
                        end
                        FN_UNL_AFTER:
                        begin
                            if (!slot_ok)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_BAD_SLOT;
                            end
                            else
                            begin
                                mem_ctl.nx_re = 1'b1;
                                nx_raddr      = SW'(req.slot);
                                op_slot_next  = SW'(req.slot);
                                state_next    = S_UNL1;
                            end
                        end
                        FN_UNL_FIRST:
                        begin
                            if (head_reg >= alloc_reg)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_NO_NEXT;
                            end
                            else
                            begin
                                mem_ctl.nx_re = 1'b1;
                                nx_raddr      = head_reg[SW-1:0];
                                state_next    = S_POP;
                            end
                        end
                        FN_READ_NEXT:
                        begin
                            if (walk_ptr >= alloc_reg)
                            begin
                                // End of list: rewind so the next read starts at the head
                                fin          = 1'b1;
                                fin_status   = ST_END;
                                cur_next     = NULL_PTR;
                                started_next = 1'b0;
                            end
                            else
                            begin
                                mem_ctl.nx_re = 1'b1;
                                mem_ctl.vl_re = 1'b1;
                                nx_raddr      = walk_ptr[SW-1:0];
                                vl_raddr      = walk_ptr[SW-1:0];
                                op_slot_next  = walk_ptr[SW-1:0];
                                started_next  = 1'b1;
                                state_next    = S_WALK;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_LINK:
            begin
                // New node takes over the old link of its predecessor
                mem_ctl.nx_we = 1'b1;
                nx_waddr      = op_slot_reg;
                nx_wdata      = nx_rdata;
                fin           = 1'b1;
                fin_slot      = SLOT_W'(op_slot_reg);
                state_next    = S_IDLE;
            end
            S_UNL1:
            begin
                if (nx_rdata >= alloc_reg)
                begin
                    fin        = 1'b1;
                    fin_status = ST_NO_NEXT;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_ctl.nx_re = 1'b1;
                    nx_raddr      = nx_rdata[SW-1:0];
                    state_next    = S_UNL2;
                end
            end
            S_UNL2:
            begin
                // Skip the successor
                mem_ctl.nx_we = 1'b1;
                nx_waddr      = op_slot_reg;
                nx_wdata      = nx_rdata;
                fin           = 1'b1;
                state_next    = S_IDLE;
            end
            S_POP:
            begin
                head_next  = nx_rdata;
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                cur_next   = nx_rdata;
                fin        = 1'b1;
                fin_slot   = SLOT_W'(op_slot_reg);
                fin_data   = DATA_W'(signed'(vl_rdata));
                fin_last   = (nx_rdata >= alloc_reg);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= NULL_PTR;
            alloc_reg    <= '0;
            cur_reg      <= NULL_PTR;
            started_reg  <= 1'b0;
            rs_valid_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            alloc_reg   <= alloc_next;
            cur_reg     <= cur_next;
            started_reg <= started_next;
            if (fin)
            begin
                rs_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                rs_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_slot_reg <= op_slot_next;
        if (fin)
        begin
            rs_status_reg <= fin_status;
            rs_slot_reg   <= fin_slot;
            rs_data_reg   <= fin_data;
            rs_last_reg   <= fin_last;
        end
        if (out_load)
        begin
            o_status_reg <= rs_status_reg;
            o_slot_reg   <= rs_slot_reg;
            o_data_reg   <= rs_data_reg;
            o_last_reg   <= rs_last_reg;
        end
    end

    assign rsp.valid    = ov_reg;
    assign rsp.status   = o_status_reg;
    assign rsp.out_slot = o_slot_reg;
    assign rsp.out_data = signed'(o_data_reg);
    assign rsp.last     = o_last_reg;

`ifndef SYNTHESIS
    a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_reg <= NULL_PTR)
        else $error("slot counter beyond pool size");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg < alloc_reg) || (head_reg == NULL_PTR))
        else $error("head points at an unallocated slot");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> !rs_valid_reg)
        else $error("result completed while holding stage occupied");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (rs_valid_reg || (state_reg != S_IDLE)))
        else $error("accepted request left no trace");
`endif

endmodule

>>> rtl/core/sll_store.sv
// Link and value memories of the linked list engine, one read and one write port each.
module sll_store #(
    parameter int NODES      = sll_pkg::NODES_DEF,
    parameter int VALUE_BITS = sll_pkg::VALUE_BITS_DEF
) (
    input  logic                           clk,
    input  sll_pkg::mem_ctl_t              ctl,
    input  logic [$clog2(NODES)-1:0]       nx_raddr,
    input  logic [$clog2(NODES)-1:0]       nx_waddr,
    input  logic [$clog2(NODES+1)-1:0]     nx_wdata,
    output logic [$clog2(NODES+1)-1:0]     nx_rdata,
    input  logic [$clog2(NODES)-1:0]       vl_raddr,
    input  logic [$clog2(NODES)-1:0]       vl_waddr,
    input  logic [VALUE_BITS-1:0]          vl_wdata,
    output logic [VALUE_BITS-1:0]          vl_rdata
);
    import sll_pkg::*;

    localparam int PW = $clog2(NODES + 1);

    logic [PW-1:0]         next_mem [NODES];
    logic [VALUE_BITS-1:0] value_mem [NODES];

    // Read-first: a read and a write of the same entry in one cycle return the old link
    always_ff @(posedge clk)
    begin
        if (ctl.nx_we)
        begin
            next_mem[nx_waddr] <= nx_wdata;
        end
        if (ctl.nx_re)
        begin
            nx_rdata <= next_mem[nx_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.vl_we)
        begin
            value_mem[vl_waddr] <= vl_wdata;
        end
        if (ctl.vl_re)
        begin
            vl_rdata <= value_mem[vl_raddr];
        end
    end

endmodule
